FILE: rtl/lc3x_pkg.sv
// ----------------------------------------------------------------------------
// lc3x_pkg
// Shared codes, result type and small helpers for the 16-bit ISA executor.
// ----------------------------------------------------------------------------
package lc3x_pkg;

  localparam logic [1:0] OPER_EXEC  = 2'd0;
  localparam logic [1:0] OPER_WRITE = 2'd1;
  localparam logic [1:0] OPER_READ  = 2'd2;
  localparam logic [1:0] OPER_NONE  = 2'd3;

  localparam logic [3:0] OPC_BR   = 4'd0;
  localparam logic [3:0] OPC_ADD  = 4'd1;
  localparam logic [3:0] OPC_LD   = 4'd2;
  localparam logic [3:0] OPC_ST   = 4'd3;
  localparam logic [3:0] OPC_JSR  = 4'd4;
  localparam logic [3:0] OPC_AND  = 4'd5;
  localparam logic [3:0] OPC_LDR  = 4'd6;
  localparam logic [3:0] OPC_STR  = 4'd7;
  localparam logic [3:0] OPC_RTI  = 4'd8;
  localparam logic [3:0] OPC_NOT  = 4'd9;
  localparam logic [3:0] OPC_LDI  = 4'd10;
  localparam logic [3:0] OPC_STI  = 4'd11;
  localparam logic [3:0] OPC_JMP  = 4'd12;
  localparam logic [3:0] OPC_RES  = 4'd13;
  localparam logic [3:0] OPC_LEA  = 4'd14;
  localparam logic [3:0] OPC_TRAP = 4'd15;

  localparam logic [2:0] CC_P = 3'b001;
  localparam logic [2:0] CC_Z = 3'b010;
  localparam logic [2:0] CC_N = 3'b100;

  localparam logic [15:0] START_PC_RST = 16'h3000;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_START_PC = 2'd0;

  typedef struct packed {
    logic [15:0] pc;
    logic [2:0]  cond;
    logic        rw_vld;
    logic [2:0]  rw_idx;
    logic [15:0] rw_val;
    logic        mw_vld;
    logic [15:0] mw_addr;
    logic [15:0] mw_val;
    logic [15:0] read_data;
    logic        fault;
  } res_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] c;
    if (v == 16'd0) begin
      c = CC_Z;
    end else if (v[15]) begin
      c = CC_N;
    end else begin
      c = CC_P;
    end
    return c;
  endfunction

  function automatic logic [15:0] sext5(input logic [4:0] v);
    return {{11{v[4]}}, v};
  endfunction

  function automatic logic [15:0] sext6(input logic [5:0] v);
    return {{10{v[5]}}, v};
  endfunction

  function automatic logic [15:0] sext9(input logic [8:0] v);
    return {{7{v[8]}}, v};
  endfunction

  function automatic logic [15:0] sext11(input logic [10:0] v);
    return {{5{v[10]}}, v};
  endfunction

  function automatic logic is_store(input logic [3:0] opc);
    return opc inside {OPC_ST, OPC_STI, OPC_STR};
  endfunction

endpackage

FILE: rtl/lc3x_ram.sv
// ----------------------------------------------------------------------------
// lc3x_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lc3x_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/sixteen_bit_isa_executor.sv
// ----------------------------------------------------------------------------
// sixteen_bit_isa_executor
// Executes LC-3 instructions and memory load/check beats against an internal
// register file, PC, condition code and word memory.
// ----------------------------------------------------------------------------
// ALU, branch, jump, LEA, ST, STR, TRAP, memory write beats and faults finish
// in the execute state and may follow one another every cycle unless the
// output stalls. LD, LDR, STI and memory read beats also pass through state
// M1, LDI also M2: one state per registered word-memory read. The register
// file sits in two 8-entry RAMs (one per read operand) with a forwarding path
// for a write that lands at the edge an instruction is taken. A result waits
// in the output register while the next beat is being executed.
module sixteen_bit_isa_executor
  import lc3x_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_operation,
  input  logic [15:0]           in_instr,
  input  logic [15:0]           in_address,
  input  logic [15:0]           in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_pc,
  output logic [2:0]            out_cond,
  output logic                  out_reg_write_valid,
  output logic [2:0]            out_reg_write_index,
  output logic [15:0]           out_reg_write_value,
  output logic                  out_mem_write_valid,
  output logic [15:0]           out_mem_write_addr,
  output logic [15:0]           out_mem_write_value,
  output logic [15:0]           out_read_data,
  output logic                  out_fault,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;
  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EX   = 2'd1;
  localparam logic [1:0] S_M1   = 2'd2;
  localparam logic [1:0] S_M2   = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic        out_valid_r;
  res_t        out_res_r;
  res_t        res;
  logic [15:0] pc_r, start_pc_r;
  logic [2:0]  cond_r;

  logic [1:0]  op_r;
  logic [15:0] instr_r, addr_r, data_r;
  logic [15:0] pcn_r, rb_r;

  logic [7:0]  rf_vld_r;
  logic        fwd_vld_r;
  logic [2:0]  fwd_idx_r;
  logic [15:0] fwd_val_r;

  logic        can_out, done, fin, acc, go_m1, go_m2;
  logic        rd_issue, mem_we_req, mem_we, rf_we, cfg_wr;
  logic [15:0] rd_addr, mem_wa16, mem_wd;
  logic [ADDR_BITS-1:0] mem_ra, mem_ra_hold_r;
  logic [15:0] mem_q;

  logic [3:0]  opc;
  logic [2:0]  dr, sr1, sr2, rb_sel;
  logic [2:0]  ra_a, rb_a;
  logic [15:0] ra_q, rb_q, ra_val, rb_val;
  logic [15:0] pc_inc, pc9, boff, alu_b;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == REG_START_PC);
  assign cfg_prdata = (cfg_paddr == REG_START_PC) ? {16'd0, start_pc_r} : 32'd0;

  // handshake
  assign can_out  = !out_valid_r || out_ready;
  assign fin      = done && can_out;
  assign in_ready = can_out && ((state_r == S_IDLE) || done);
  assign acc      = in_valid && in_ready;

  // instruction fields
  assign opc    = instr_r[15:12];
  assign dr     = instr_r[11:9];
  assign sr1    = instr_r[8:6];
  assign sr2    = instr_r[2:0];
  assign rb_sel = is_store(opc) ? dr : sr2;

  // register file reads
  assign ra_a = acc ? in_instr[8:6] : sr1;
  assign rb_a = acc ? (is_store(in_instr[15:12]) ? in_instr[11:9] : in_instr[2:0]) : rb_sel;

  lc3x_ram #(.WIDTH(16), .DEPTH(8)) u_rf_a (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (res.rw_idx),
    .wdata   (res.rw_val),
    .raddr   (ra_a),
    .rdata_r (ra_q)
  );

  lc3x_ram #(.WIDTH(16), .DEPTH(8)) u_rf_b (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (res.rw_idx),
    .wdata   (res.rw_val),
    .raddr   (rb_a),
    .rdata_r (rb_q)
  );

  assign ra_val = (fwd_vld_r && fwd_idx_r == sr1) ? fwd_val_r :
                  (rf_vld_r[sr1] ? ra_q : 16'd0);
  assign rb_val = (fwd_vld_r && fwd_idx_r == rb_sel) ? fwd_val_r :
                  (rf_vld_r[rb_sel] ? rb_q : 16'd0);

  // word memory
  assign mem_ra = rd_issue ? rd_addr[ADDR_BITS-1:0] : mem_ra_hold_r;
  assign mem_we = mem_we_req && fin;

  lc3x_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_wa16[ADDR_BITS-1:0]),
    .wdata   (mem_wd),
    .raddr   (mem_ra),
    .rdata_r (mem_q)
  );

  // address arithmetic
  assign pc_inc = pc_r + 16'd1;
  assign pc9    = pc_inc + sext9(instr_r[8:0]);
  assign boff   = ra_val + sext6(instr_r[5:0]);
  assign alu_b  = instr_r[5] ? sext5(instr_r[4:0]) : rb_val;

  always_comb begin
    res        = '0;
    res.pc     = pc_r;
    res.cond   = cond_r;
    done       = 1'b0;
    go_m1      = 1'b0;
    go_m2      = 1'b0;
    rd_issue   = 1'b0;
    rd_addr    = 16'd0;
    mem_we_req = 1'b0;
    mem_wa16   = addr_r;
    mem_wd     = data_r;
    case (state_r)
      S_EX: begin
        case (op_r)
          OPER_WRITE: begin
            mem_we_req = 1'b1;
            done       = 1'b1;
          end
          OPER_READ: begin
            rd_issue = 1'b1;
            rd_addr  = addr_r;
            go_m1    = 1'b1;
          end
          OPER_EXEC: begin
            if (opc == OPC_RTI || opc == OPC_RES) begin
              res.fault = 1'b1;
              done      = 1'b1;
            end else begin
              res.pc = pc_inc;
              done   = 1'b1;
              case (opc)
                OPC_BR: begin
                  if ((dr & cond_r) != 3'd0) begin
                    res.pc = pc9;
                  end
                end
                OPC_ADD, OPC_AND, OPC_NOT, OPC_LEA: begin
                  res.rw_vld = 1'b1;
                  res.rw_idx = dr;
                  case (opc)
                    OPC_ADD: res.rw_val = ra_val + alu_b;
                    OPC_AND: res.rw_val = ra_val & alu_b;
                    OPC_NOT: res.rw_val = ~ra_val;
                    default: res.rw_val = pc9;
                  endcase
                  res.cond = cc_of(res.rw_val);
                end
                OPC_JMP: res.pc = ra_val;
                OPC_JSR: begin
                  res.pc     = instr_r[11] ? pc_inc + sext11(instr_r[10:0]) : ra_val;
                  res.rw_vld = 1'b1;
                  res.rw_idx = 3'd7;
                  res.rw_val = pc_inc;
                end
                OPC_LD, OPC_LDI, OPC_STI: begin
                  done     = 1'b0;
                  go_m1    = 1'b1;
                  rd_issue = 1'b1;
                  rd_addr  = pc9;
                end
                OPC_LDR: begin
                  done     = 1'b0;
                  go_m1    = 1'b1;
                  rd_issue = 1'b1;
                  rd_addr  = boff;
                end
                OPC_ST, OPC_STR: begin
                  res.mw_vld  = 1'b1;
                  res.mw_addr = ((opc == OPC_ST) ? pc9 : boff) & ADDR_MASK;
                  res.mw_val  = rb_val;
                  mem_we_req  = 1'b1;
                  mem_wa16    = res.mw_addr;
                  mem_wd      = rb_val;
                end
                default: ;
              endcase
            end
          end
          default: done = 1'b1;
        endcase
      end
      S_M1: begin
        res.pc = pcn_r;
        if (op_r == OPER_READ) begin
          res.read_data = mem_q;
          done          = 1'b1;
        end else if (opc == OPC_LDI) begin
          rd_issue = 1'b1;
          rd_addr  = mem_q;
          go_m2    = 1'b1;
        end else if (opc == OPC_STI) begin
          res.mw_vld  = 1'b1;
          res.mw_addr = mem_q & ADDR_MASK;
          res.mw_val  = rb_r;
          mem_we_req  = 1'b1;
          mem_wa16    = res.mw_addr;
          mem_wd      = rb_r;
          done        = 1'b1;
        end else begin
          res.rw_vld = 1'b1;
          res.rw_idx = dr;
          res.rw_val = mem_q;
          res.cond   = cc_of(mem_q);
          done       = 1'b1;
        end
      end
      S_M2: begin
        res.pc     = pcn_r;
        res.rw_vld = 1'b1;
        res.rw_idx = dr;
        res.rw_val = mem_q;
        res.cond   = cc_of(mem_q);
        done       = 1'b1;
      end
      default: ;
    endcase
  end

  assign rf_we = fin && res.rw_vld;

  always_comb begin
    if (acc) begin
      state_nxt = S_EX;
    end else if (fin) begin
      state_nxt = S_IDLE;
    end else if (go_m1) begin
      state_nxt = S_M1;
    end else if (go_m2) begin
      state_nxt = S_M2;
    end else begin
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= START_PC_RST;
      start_pc_r  <= START_PC_RST;
      cond_r      <= CC_Z;
      rf_vld_r    <= 8'd0;
      fwd_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (fin) begin
        pc_r   <= res.pc;
        cond_r <= res.cond;
      end
      if (cfg_wr) begin
        start_pc_r <= cfg_pwdata[15:0];
        pc_r       <= cfg_pwdata[15:0];
      end
      if (rf_we) begin
        rf_vld_r[res.rw_idx] <= 1'b1;
      end
      fwd_vld_r <= rf_we;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r    <= in_operation;
      instr_r <= in_instr;
      addr_r  <= in_address;
      data_r  <= in_data;
    end
    if (fin) begin
      out_res_r <= res;
    end
    if (rf_we) begin
      fwd_idx_r <= res.rw_idx;
      fwd_val_r <= res.rw_val;
    end
    if (state_r == S_EX && go_m1) begin
      pcn_r <= res.pc;
      rb_r  <= rb_val;
    end
    mem_ra_hold_r <= mem_ra;
  end

  assign out_valid           = out_valid_r;
  assign out_pc              = out_res_r.pc;
  assign out_cond            = out_res_r.cond;
  assign out_reg_write_valid = out_res_r.rw_vld;
  assign out_reg_write_index = out_res_r.rw_idx;
  assign out_reg_write_value = out_res_r.rw_val;
  assign out_mem_write_valid = out_res_r.mw_vld;
  assign out_mem_write_addr  = out_res_r.mw_addr;
  assign out_mem_write_value = out_res_r.mw_val;
  assign out_read_data       = out_res_r.read_data;
  assign out_fault           = out_res_r.fault;

  a_cond_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_cond))
    else $error("condition code not one-hot");

  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault) |-> (!out_reg_write_valid && !out_mem_write_valid))
    else $error("faulting beat wrote state");

  a_accept_ex: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == S_EX))
    else $error("accepted beat not in execute");

  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_vld_r |-> $past(rf_we))
    else $error("forward without register write");

endmodule
